// File: hw/rtl/chtab_pkg.sv
// Shared constants, types and the bucket-hash step for the chained hash table.
// No dependencies; every module of the block imports this package.
`default_nettype none

package chtab_pkg;

    // Table geometry
    localparam int BUCKETS  = 13;
    localparam int NODES    = 64;
    localparam int KEY_BITS = 16;

    // Port widths fixed by the interface
    localparam int KEY_W = 16;
    localparam int CNT_W = 7;

    // Node pointer holds an index or the null code NODES
    localparam int NODE_W = $clog2(NODES + 1);
    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [NODE_W-1:0] NIL = NODE_W'(NODES);

    // Bucket index and the hash digit walk (one nibble per step)
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MOD_W   = BKT_W + 5;
    localparam int KEY_NIB = (KEY_BITS + 3) / 4;
    localparam int KEY_PAD = KEY_NIB * 4;
    localparam int NIB_CW  = $clog2(KEY_NIB + 1);
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    // Opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_COUNT  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Node memory write port
    typedef struct packed {
        logic              key_en;
        logic              link_en;
        logic [IDX_W-1:0]  addr;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] link;
    } t_node_wr;

    // Node memory read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_node_rd;

    // One hash step: (rem * 16 + nib) mod BUCKETS, with rem < BUCKETS.
    // The value stays below 16 * BUCKETS, so four restoring subtracts suffice.
    function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                  input logic [3:0]       nib);
        logic [MOD_W-1:0] v;
        logic [MOD_W-1:0] sub;
        v = {1'b0, rem, nib};
        for (int s = 3; s >= 0; s--) begin
            sub = MOD_W'(BUCKETS) << s;
            if (v >= sub) begin
                v = v - sub;
            end
        end
        return v[BKT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chtab_hash.sv
// Iterative bucket hash: key mod BUCKETS, one key nibble per cycle.
// Depends on chtab_pkg for widths and the mod_step function.
`default_nettype none

module chtab_hash import chtab_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_done,
    output logic [BKT_W-1:0]      o_bucket
);

    logic              r_busy;
    logic              r_done;
    logic [NIB_CW-1:0] r_cnt;
    logic [KEY_PAD-1:0] r_sh;
    logic [BKT_W-1:0]  r_rem;

    // Load the key, then fold in the top nibble each cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NIB_CW'(KEY_NIB);
                r_sh   <= KEY_PAD'(i_key[KEY_BITS-1:0]);
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= mod_step(r_rem, r_sh[KEY_PAD-1 -: 4]);
                r_sh  <= r_sh << 4;
                r_cnt <= r_cnt - NIB_CW'(1);
                if (r_cnt == NIB_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

`default_nettype wire

// File: hw/rtl/chtab_node_mem.sv
// Node pool memory: key and link per node, one write and one registered read a cycle.
// Depends on chtab_pkg for the port structs and widths.
`default_nettype none

module chtab_node_mem import chtab_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_node_wr i_wr,
    input  wire t_node_rd i_rd,
    output logic [KEY_W-1:0]  o_rd_key,
    output logic [NODE_W-1:0] o_rd_link
);

    logic [KEY_W-1:0]  r_key_mem  [NODES];
    logic [NODE_W-1:0] r_link_mem [NODES];

    // Write key and link fields independently
    always_ff @(posedge i_clk) begin
        if (i_wr.key_en) begin
            r_key_mem[i_wr.addr] <= i_wr.key;
        end
        if (i_wr.link_en) begin
            r_link_mem[i_wr.addr] <= i_wr.link;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_rd_key  <= r_key_mem[i_rd.addr];
            o_rd_link <= r_link_mem[i_rd.addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/chained_hash_table.sv
// Top level of the chained hash table: sequencer, bucket heads, free list and counters.
// Depends on chtab_pkg, chtab_hash and chtab_node_mem.
`default_nettype none

// Separate-chaining hash table over a pool of NODES nodes and BUCKETS chains.
// One operation is in flight at a time: o_stall is high from the transfer of an
// item until its result is loaded into the output register. The bucket hash folds
// one key nibble per cycle. With the output register free, a count goes straight
// to the result; an insert that reuses a freed node adds one free-list read
// (S_ALLOC); search and delete walk the chain, each node costing one registered
// read of the node memory and one compare, and a miss ends in S_WALK_RD, which
// detects the end of the chain; a delete hit adds S_FREE to push the node onto
// the free list.
// The output register holds a finished result while i_stall is high; reset needs no
// clearing pass.
module chained_hash_table import chtab_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_status,
    output logic [KEY_W-1:0]      o_found_key,
    output logic [CNT_W-1:0]      o_entry_count
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_HASH     = 4'd1;
    localparam logic [3:0] S_ALLOC    = 4'd2;
    localparam logic [3:0] S_INS      = 4'd3;
    localparam logic [3:0] S_WALK_RD  = 4'd4;
    localparam logic [3:0] S_WALK_CMP = 4'd5;
    localparam logic [3:0] S_FREE     = 4'd6;
    localparam logic [3:0] S_DONE     = 4'd7;

    logic [3:0]        r_state;
    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [BKT_W-1:0]  r_bkt;
    logic [NODE_W-1:0] r_head [BUCKETS];
    logic [NODE_W-1:0] r_free_head;
    logic [NODE_W-1:0] r_fresh;
    logic [NODE_W-1:0] r_count;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_prev;
    logic [NODE_W-1:0] r_steps;
    logic [1:0]        r_status;
    logic [KEY_W-1:0]  r_fkey;
    logic              r_out_valid;

    logic              in_xfer;
    logic              hash_start;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bkt;
    logic              free_avail;
    logic              walk_ok;
    logic              key_hit;
    logic              out_free;
    logic [KEY_W-1:0]  in_key;
    t_node_wr          node_wr;
    t_node_rd          node_rd;
    logic [KEY_W-1:0]  rd_key;
    logic [NODE_W-1:0] rd_link;

    assign o_stall    = (r_state != S_IDLE);
    assign in_xfer    = i_valid && !o_stall;
    assign in_key     = i_key & KEY_MASK;
    assign hash_start = in_xfer && (i_opcode != OP_COUNT);
    assign free_avail = (r_free_head < NIL);
    assign walk_ok    = (r_cur < NIL) && (r_steps != NIL);
    assign key_hit    = (rd_key == r_key);
    assign out_free   = !r_out_valid || !i_stall;

    chtab_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (in_key),
        .o_done   (hash_done),
        .o_bucket (hash_bkt)
    );

    // Node memory reads: free-list pop or chain walk
    always_comb begin
        node_rd.en   = 1'b0;
        node_rd.addr = r_cur[IDX_W-1:0];
        if (r_state == S_HASH) begin
            node_rd.en   = hash_done && (r_op == OP_INSERT) && free_avail;
            node_rd.addr = r_free_head[IDX_W-1:0];
        end else if (r_state == S_WALK_RD) begin
            node_rd.en = walk_ok;
        end
    end

    // Node memory writes: new node, relink of predecessor, push onto free list
    always_comb begin
        node_wr.key_en  = 1'b0;
        node_wr.link_en = 1'b0;
        node_wr.addr    = r_node[IDX_W-1:0];
        node_wr.key     = r_key;
        node_wr.link    = r_head[r_bkt];
        case (r_state)
            S_INS: begin
                node_wr.key_en  = 1'b1;
                node_wr.link_en = 1'b1;
            end
            S_WALK_CMP: begin
                node_wr.link_en = key_hit && (r_op == OP_DELETE) && (r_prev < NIL);
                node_wr.addr    = r_prev[IDX_W-1:0];
                node_wr.link    = rd_link;
            end
            S_FREE: begin
                node_wr.link_en = 1'b1;
                node_wr.addr    = r_cur[IDX_W-1:0];
                node_wr.link    = r_free_head;
            end
            default: begin
                node_wr.link_en = 1'b0;
            end
        endcase
    end

    chtab_node_mem u_node_mem (
        .i_clk     (i_clk),
        .i_wr      (node_wr),
        .i_rd      (node_rd),
        .o_rd_key  (rd_key),
        .o_rd_link (rd_link)
    );

    // Sequencer, bucket heads, free list and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            // Load a finished result, or drop the held one once it has been taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op  <= i_opcode;
                        r_key <= in_key;
                        if (i_opcode == OP_COUNT) begin
                            r_status <= ST_OK;
                            r_fkey   <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_bkt  <= hash_bkt;
                        r_fkey <= '0;
                        if (r_op == OP_INSERT) begin
                            if (free_avail) begin
                                r_state <= S_ALLOC;
                            end else if (r_fresh < NIL) begin
                                r_node  <= r_fresh;
                                r_fresh <= r_fresh + NODE_W'(1);
                                r_state <= S_INS;
                            end else begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_cur   <= r_head[hash_bkt];
                            r_prev  <= NIL;
                            r_steps <= '0;
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_ALLOC: begin
                    r_node      <= r_free_head;
                    r_free_head <= rd_link;
                    r_state     <= S_INS;
                end
                S_INS: begin
                    r_head[r_bkt] <= r_node;
                    r_count       <= r_count + NODE_W'(1);
                    r_status      <= ST_OK;
                    r_state       <= S_DONE;
                end
                S_WALK_RD: begin
                    if (!walk_ok) begin
                        r_status <= ST_ABSENT;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_WALK_CMP;
                    end
                end
                S_WALK_CMP: begin
                    if (key_hit) begin
                        if (r_op == OP_DELETE) begin
                            if (!(r_prev < NIL)) begin
                                r_head[r_bkt] <= rd_link;
                            end
                            r_state <= S_FREE;
                        end else begin
                            r_status <= ST_OK;
                            r_fkey   <= rd_key;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= rd_link;
                        r_steps <= r_steps + NODE_W'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_FREE: begin
                    r_free_head <= r_cur;
                    if (r_count != '0) begin
                        r_count <= r_count - NODE_W'(1);
                    end
                    r_status <= ST_OK;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        o_status      <= r_status;
                        o_found_key   <= r_fkey;
                        o_entry_count <= CNT_W'(r_count);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

    // A full pool means every node is stored
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_entry_count == CNT_W'(NODES)))
        else $error("pool full reported with free nodes left");

    // Only a successful search carries a key
    a_fkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_found_key == '0))
        else $error("found key set on a failed operation");

    // Stored entries never exceed the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above pool size");

    // The hash finishes only while the sequencer waits for it
    a_hash_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("hash done outside hash state");

endmodule

`default_nettype wire
